// ===== hdl/pixel_range_background_model_defines.svh =====
// Assertion macros shared by the pixel range background model.
`ifndef PIXEL_RANGE_BACKGROUND_MODEL_DEFINES_SVH
`define PIXEL_RANGE_BACKGROUND_MODEL_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PRBM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("prbm same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PRBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("prbm next-cycle check failed");

`endif

// ===== hdl/prbm_pkg.sv =====
// Types, codes and the per-pixel update function of the range background model.
package prbm_pkg;

	typedef enum logic [2:0] {
		MODE_GROW_SLOW     = 3'd0,
		MODE_GROW_FAST     = 3'd1,
		MODE_COUNT         = 3'd2,
		MODE_ADJUST        = 3'd3,
		MODE_ADJUST_MASKED = 3'd4,
		MODE_SHIFT         = 3'd5,
		MODE_SHIFT_MASKED  = 3'd6,
		MODE_LOAD          = 3'd7
	} mode_t;

	typedef enum logic [0:0] {
		CFG_MODE      = 1'b0,
		CFG_THRESHOLD = 1'b1
	} cfg_reg_t;

	localparam logic [2:0] MODE_RESET = 3'd7;

	typedef struct packed {
		logic [7:0] low;
		logic [7:0] high;
		logic [7:0] low_count;
		logic [7:0] high_count;
	} entry_t;

	typedef struct packed {
		logic [15:0] index;
		logic [7:0]  value;
		logic        en;
		logic        in_range;
	} item_t;

	// Head of the queue as the back end sees it.
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	function automatic logic [7:0] sat_inc(logic [7:0] a);
		return (a == 8'hff) ? a : a + 8'd1;
	endfunction

	function automatic logic [7:0] sat_dec(logic [7:0] a);
		return (a == 8'h00) ? a : a - 8'd1;
	endfunction

	function automatic logic [7:0] sat_add(logic [7:0] a, logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[8] ? 8'hff : s[7:0];
	endfunction

	function automatic logic [7:0] sat_sub(logic [7:0] a, logic [7:0] b);
		return (a > b) ? a - b : 8'd0;
	endfunction

	function automatic entry_t update_entry(mode_t m, logic [7:0] thr, logic [7:0] v,
		logic en, entry_t cur);
		entry_t     nxt;
		logic [7:0] add_v;
		logic [7:0] sub_v;
		nxt   = cur;
		add_v = sat_sub(v, cur.high);
		sub_v = sat_sub(cur.low, v);
		case (m)
			MODE_GROW_SLOW: begin
				if (v > cur.high) nxt.high = sat_inc(cur.high);
				if (v < cur.low)  nxt.low  = sat_dec(cur.low);
			end
			MODE_GROW_FAST: begin
				if (v < cur.low)  nxt.low  = v;
				if (v > cur.high) nxt.high = v;
			end
			MODE_COUNT: begin
				if (v < cur.low)  nxt.low_count  = sat_inc(cur.low_count);
				if (v > cur.high) nxt.high_count = sat_inc(cur.high_count);
			end
			MODE_ADJUST, MODE_ADJUST_MASKED: begin
				if (m == MODE_ADJUST || en) begin
					if (cur.low_count > thr)      nxt.low = sat_dec(cur.low);
					else if (cur.low_count < thr) nxt.low = sat_inc(cur.low);
					if (cur.high_count > thr)      nxt.high = sat_inc(cur.high);
					else if (cur.high_count < thr) nxt.high = sat_dec(cur.high);
				end
				nxt.low_count  = 8'd0;
				nxt.high_count = 8'd0;
			end
			MODE_SHIFT, MODE_SHIFT_MASKED: begin
				if (m == MODE_SHIFT || en) begin
					nxt.low  = sat_sub(sat_add(cur.low, add_v), sub_v);
					nxt.high = sat_sub(sat_add(cur.high, add_v), sub_v);
				end
			end
			default: begin
				nxt.low        = v;
				nxt.high       = v;
				nxt.low_count  = 8'd0;
				nxt.high_count = 8'd0;
			end
		endcase
		return nxt;
	endfunction

endpackage

// ===== hdl/prbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prbm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/prbm_front.sv =====
// Front end: accepts pixel items, classifies them and queues them for the back end.
module prbm_front import prbm_pkg::*; #(
	parameter int PIXELS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] pixel_index,
	input  logic [7:0]  pixel_value,
	input  logic [7:0]  pixel_mask,
	output q_head_t     head,
	input  logic        pop
);

	item_t       slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	item_t       new_item;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;

	always_comb begin
		new_item.index    = pixel_index;
		new_item.value    = pixel_value;
		new_item.en       = (pixel_mask != 8'd0);
		new_item.in_range = ({16'd0, pixel_index} < 32'(PIXELS));
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head.valid = (count_q != 2'd0);
	assign head.item  = slot_q[rd_ptr_q];

endmodule

// ===== hdl/prbm_back.sv =====
// Back end: reads the pixel entry, applies the mode update, writes it back and delivers the result.
module prbm_back import prbm_pkg::*; #(
	parameter int PIXELS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  q_head_t     head,
	output logic        pop,
	input  mode_t       mode,
	input  logic [7:0]  threshold,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] out_index,
	output logic [7:0]  out_low,
	output logic [7:0]  out_high,
	output logic [7:0]  out_low_count,
	output logic [7:0]  out_high_count
);

	localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

	logic          valid_s1;
	item_t         item_s1;
	logic          go;
	logic [31:0]   rd_ext;
	logic [31:0]   s1_ext;
	logic [AW-1:0] raddr;
	logic [AW-1:0] addr_s1;
	entry_t        rd_data;
	entry_t        cur;
	entry_t        nxt;
	logic          fwd_valid_q;
	logic [AW-1:0] fwd_addr_q;
	entry_t        fwd_data_q;
	logic          out_valid_q;
	logic [15:0]   out_index_q;
	entry_t        out_entry_q;

	assign go  = valid_s1 && (!out_valid_q || !out_stall);
	assign pop = head.valid && (!valid_s1 || go);

	assign rd_ext  = {16'd0, head.item.index};
	assign s1_ext  = {16'd0, item_s1.index};
	assign raddr   = rd_ext[AW-1:0];
	assign addr_s1 = s1_ext[AW-1:0];

	prbm_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (PIXELS)
	) u_ram (
		.clk   (clk),
		.we    (go && item_s1.in_range),
		.waddr (addr_s1),
		.wdata (nxt),
		.re    (pop && head.item.in_range),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// A read issued in the same cycle as the previous write to that pixel sees old data,
	// so the last written entry is kept and takes precedence on an address match.
	always_comb begin
		cur = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_data;
		nxt = update_entry(mode, threshold, item_s1.value, item_s1.en, cur);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head.item;
		end
		if (go && item_s1.in_range) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= nxt;
		end
		if (go) begin
			out_index_q <= item_s1.index;
			out_entry_q <= item_s1.in_range ? nxt : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			if (go && item_s1.in_range) begin
				fwd_valid_q <= 1'b1;
			end
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign out_index      = out_index_q;
	assign out_low        = out_entry_q.low;
	assign out_high       = out_entry_q.high;
	assign out_low_count  = out_entry_q.low_count;
	assign out_high_count = out_entry_q.high_count;

endmodule

// ===== hdl/pixel_range_background_model.sv =====
// Pixel range background model top level: configuration registers, front end, back end.
// Throughput: one item per cycle while out_stall is low, set by the single read and single
// write port of the entry RAM. Items pass the queue, stage one and the output register.
// Reset: clears handshake state, the queue and forwarding state; mode resets to load and
// threshold to zero. The entry RAM is not cleared and needs a load before other modes.
`include "pixel_range_background_model_defines.svh"
module pixel_range_background_model import prbm_pkg::*; #(
	parameter int PIXELS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] pixel_index,
	input  logic [7:0]  pixel_value,
	input  logic [7:0]  pixel_mask,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] out_index,
	output logic [7:0]  out_low,
	output logic [7:0]  out_high,
	output logic [7:0]  out_low_count,
	output logic [7:0]  out_high_count
);

	mode_t      mode_q;
	logic [7:0] threshold_q;
	q_head_t    head;
	logic       pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= mode_t'(MODE_RESET);
			threshold_q <= 8'd0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_MODE:      mode_q      <= mode_t'(cfg_data[2:0]);
				CFG_THRESHOLD: threshold_q <= cfg_data;
				default:       threshold_q <= threshold_q;
			endcase
		end
	end

	prbm_front #(
		.PIXELS (PIXELS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_index (pixel_index),
		.pixel_value (pixel_value),
		.pixel_mask  (pixel_mask),
		.head        (head),
		.pop         (pop)
	);

	prbm_back #(
		.PIXELS (PIXELS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.mode           (mode_q),
		.threshold      (threshold_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_index      (out_index),
		.out_low        (out_low),
		.out_high       (out_high),
		.out_low_count  (out_low_count),
		.out_high_count (out_high_count)
	);

	`PRBM_ASSERT_NEXT(a_accept_queued, clk, arst_n, in_valid && !in_stall, head.valid)
	`PRBM_ASSERT_IMPLY(a_out_of_range_zero, clk, arst_n,
		out_valid && ({16'd0, out_index} >= 32'(PIXELS)),
		out_low == 8'd0 && out_high == 8'd0 && out_low_count == 8'd0 && out_high_count == 8'd0)
	`PRBM_ASSERT_IMPLY(a_load_result, clk, arst_n,
		out_valid && mode_q == MODE_LOAD,
		out_low == out_high && out_low_count == 8'd0 && out_high_count == 8'd0)
	`PRBM_ASSERT_IMPLY(a_adjust_clears, clk, arst_n,
		out_valid && (mode_q == MODE_ADJUST || mode_q == MODE_ADJUST_MASKED),
		out_low_count == 8'd0 && out_high_count == 8'd0)

endmodule
